// File: rtl/spq_pkg.sv
// Shared constants, status codes and a helper function for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = 32;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Map a position in sorted order to a physical entry of the circular buffer.
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] pos);
    logic [AW+1:0] sum;
    sum = {2'b00, base} + {{(AW+2-CW){1'b0}}, pos};
    if (sum >= (AW+2)'(CAPACITY)) begin
      sum = sum - (AW+2)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/spq_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface spq_req_if;
  import spq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic signed [KW-1:0] key;
  modport source (output valid, operation, key, input ready);
  modport sink (input valid, operation, key, output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic signed [KW-1:0] taken_key;
  logic signed [KW-1:0] head_key;
  logic                 head_valid;
  logic [CW-1:0]        fill_level;
  modport source (output valid, status, taken_key, head_key, head_valid, fill_level,
                  input ready);
  modport sink (input valid, status, taken_key, head_key, head_valid, fill_level,
                output ready);
endinterface
`default_nettype wire

// File: rtl/spq_ram.sv
// Simple dual-port synchronous RAM with registered read.
`default_nettype none
module spq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Sorted min-priority queue: top level with control sequencer and key memory.
// Usage:
//   Requests arrive on the req channel (operation, key); each accepted request
//   produces exactly one result transfer on the rsp channel (status, taken_key,
//   head_key, head_valid, fill_level). Keys live in a circular buffer in one
//   RAM, ascending from a head pointer; the smallest key is also kept in a
//   register.
//   One request at a time. An extract goes from acceptance through the load
//   state, which reads the new head from the RAM, to the finish state, or
//   straight to the finish state when it empties the queue or finds it empty.
//   An insert walks down from the tail one entry per cycle, because the read
//   of the next entry overlaps the compare and write-back of the current one;
//   it moves up each stored key not less than the new one. An insert into an
//   empty or a full queue goes straight to the finish state.
//   Reset clears the fill count and the head pointer; the RAM contents are not
//   cleared and no clearing pass is needed.
//   The result sits in an output register; if the receiver stalls, the next
//   request is still accepted and processed, and its result waits until the
//   output register is free.
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_INS_CMP, S_INS_HEAD, S_EXT_LD, S_FIN
  } state_t;

  state_t               state;
  logic [AW-1:0]        hp;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic signed [KW-1:0] head;
  logic signed [KW-1:0] key_r;
  logic [1:0]           status_r;
  logic signed [KW-1:0] taken_r;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [KW-1:0]        wdata;
  logic                 re;
  logic [AW-1:0]        raddr;
  logic [KW-1:0]        rdata;
  logic                 req_fire;
  logic                 out_free;

  spq_ram #(.DEPTH(CAPACITY), .WIDTH(KW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  // Memory access control for each state.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req.operation == OP_INSERT) begin
            if (count == '0) begin
              we    = 1'b1;
              waddr = hp;
              wdata = req.key;
            end else if (count != CW'(CAPACITY)) begin
              re    = 1'b1;
              raddr = phys_addr(hp, count - CW'(1));
            end
          end else if (count > CW'(1)) begin
            re    = 1'b1;
            raddr = phys_addr(hp, CW'(1));
          end
        end
      end
      S_INS_CMP: begin
        we    = 1'b1;
        waddr = phys_addr(hp, idx);
        if ($signed(rdata) < key_r) begin
          wdata = key_r;
        end else begin
          wdata = rdata;
          if (idx > CW'(1)) begin
            re    = 1'b1;
            raddr = phys_addr(hp, idx - CW'(2));
          end
        end
      end
      S_INS_HEAD: begin
        we    = 1'b1;
        waddr = hp;
        wdata = key_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, queue bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hp        <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // A finished result replaces the outgoing one in the finish state.
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            key_r    <= req.key;
            status_r <= ST_OK;
            taken_r  <= '0;
            state    <= S_FIN;
            if (req.operation == OP_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                status_r <= ST_FULL;
              end else if (count == '0) begin
                head  <= req.key;
                count <= CW'(1);
              end else begin
                idx   <= count;
                state <= S_INS_CMP;
              end
            end else begin
              if (count == '0) begin
                status_r <= ST_EMPTY;
              end else begin
                taken_r <= head;
                hp      <= phys_addr(hp, CW'(1));
                count   <= count - CW'(1);
                if (count > CW'(1)) begin
                  state <= S_EXT_LD;
                end
              end
            end
          end
        end
        S_INS_CMP: begin
          if ($signed(rdata) < key_r) begin
            count <= count + CW'(1);
            state <= S_FIN;
          end else begin
            idx <= idx - CW'(1);
            if (idx == CW'(1)) begin
              state <= S_INS_HEAD;
            end
          end
        end
        S_INS_HEAD: begin
          head  <= key_r;
          count <= count + CW'(1);
          state <= S_FIN;
        end
        S_EXT_LD: begin
          head  <= $signed(rdata);
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp.valid      <= 1'b1;
            rsp.status     <= status_r;
            rsp.taken_key  <= taken_r;
            rsp.head_key   <= (count != '0) ? head : '0;
            rsp.head_valid <= (count != '0);
            rsp.fill_level <= count;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker
  import spq_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 rsp_valid,
  input wire logic                 rsp_ready,
  input wire logic [1:0]           status,
  input wire logic signed [KW-1:0] head_key,
  input wire logic                 head_valid,
  input wire logic [CW-1:0]        fill_level
);

  // The head flag follows the fill level.
  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (head_valid == (fill_level != '0)))
    else $error("head_valid disagrees with fill_level");

  // An empty queue reports a zero head key.
  a_head_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !head_valid) |-> (head_key == '0))
    else $error("head_key nonzero on empty queue");

  // A dropped insert only happens at capacity.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (fill_level == CW'(CAPACITY)))
    else $error("full status below capacity");

  // An empty extract only happens with nothing stored.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_EMPTY) |-> (fill_level == '0))
    else $error("empty status with keys stored");

  // A stalled result stays valid and keeps its fill level.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(fill_level)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .head_key  (rsp.head_key),
  .head_valid(rsp.head_valid),
  .fill_level(rsp.fill_level)
);
`default_nettype wire
